/* sv/smtc_pkg.sv */
// ----------------------------------------------------------------------------
// smtc_pkg
// shared types, constants and helpers of the scaled matrix transpose copy
// ----------------------------------------------------------------------------
`default_nettype none

package smtc_pkg;

    localparam int MAX_DIM     = 64;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_T = 8'h54;

    localparam logic [13:0] INDEX_LIMIT = 14'd4095;

    typedef enum logic [2:0] {
        REG_ORDER  = 3'd0,
        REG_TRANS  = 3'd1,
        REG_ROWS   = 3'd2,
        REG_COLS   = 3'd3,
        REG_SRC_LD = 3'd4,
        REG_DST_LD = 3'd5,
        REG_SCALE  = 3'd6
    } reg_index_t;

    typedef enum logic [3:0] {
        STAT_OK        = 4'd0,
        STAT_ORDER     = 4'd1,
        STAT_TRANS     = 4'd2,
        STAT_ROWS      = 4'd3,
        STAT_COLS      = 4'd4,
        STAT_SRC_LD    = 4'd5,
        STAT_DST_LD    = 4'd6,
        STAT_NOT_READY = 4'd7,
        STAT_OVERFLOW  = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_NORM,
        ST_ROUND,
        ST_FETCH
    } state_t;

    typedef struct packed {
        logic        mode;
        logic [63:0] value;
    } in_item_t;

    typedef struct packed {
        logic [63:0] value_out;
        logic [11:0] dest_index;
        logic        last;
        logic [3:0]  status;
    } out_item_t;

    function automatic logic [7:0] upcase(input logic [7:0] ch);
        upcase = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;
    endfunction

endpackage

`default_nettype wire

/* sv/scaled_matrix_transpose_copy_top.sv */
// ----------------------------------------------------------------------------
// scaled_matrix_transpose_copy_top
// B = alpha * op(A) over a 4096 x 64 result memory, binary64 scaling
// ----------------------------------------------------------------------------
// usage:
//   configure through cfg_we / cfg_index / cfg_data while idle; every write to
//   registers 0 to 6 restarts the matrix. in_data.mode = 0 loads the next element of A in
//   source order, mode = 1 fetches the next element of B in destination
//   order. every input transfer gives exactly one output transfer.
// sequencing (one item at a time):
//   status-only answers (config error, not ready): registered at the accept
//   fetch: one memory read with registered data
//   load: accept, the shared 27x27 multiplier, normalization, then
//   rounding and the write; subnormal results shift one bit a cycle
//   while normalizing.
//   zero, inf and nan operands write in the accept cycle.
// reset: config returns to column-major, copy, 1x1, alpha 1.0, counters zero;
//   the result memory is not cleared, every fetch follows its load.
// stall: the output register holds its transfer; a new input is taken once
//   the block is idle and the output register is empty or draining in that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_matrix_transpose_copy_top
    import smtc_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [63:0]     cfg_data,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire in_item_t        in_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output out_item_t            out_data
);

    logic [63:0] mem [STORE_DEPTH];

    state_t      state_reg, state_next;
    logic [7:0]  order_reg, order_next;
    logic [7:0]  trans_reg, trans_next;
    logic [6:0]  rows_reg, rows_next;
    logic [6:0]  cols_reg, cols_next;
    logic [6:0]  src_ld_reg, src_ld_next;
    logic [6:0]  dst_ld_reg, dst_ld_next;
    logic [63:0] scale_reg, scale_next;
    logic [12:0] loaded_reg, loaded_next;
    logic [12:0] fetched_reg, fetched_next;
    logic [6:0]  li_reg, li_next, lj_reg, lj_next;
    logic [6:0]  fr_reg, fr_next, fc_reg, fc_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic        sign_reg, sign_next;
    logic [52:0] ma_reg, ma_next, mb_reg, mb_next;
    logic signed [12:0] er_reg, er_next;
    logic [2:0]  step_reg, step_next;
    logic [53:0] pp_reg, pp_next;
    logic [105:0] acc_reg, acc_next;
    logic        sticky_reg, sticky_next;
    logic [11:0] fdest_reg, fdest_next;
    logic        flast_reg, flast_next;
    out_item_t   out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] rd_data_reg;

    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [63:0]       wr_data;

    // configuration check
    logic [7:0]  up_o, up_t;
    logic        is_cp, is_tr, is_cm;
    logic [6:0]  rr, rc;
    logic [13:0] total, top_idx;
    status_t     cfg_status;

    always_comb
    begin
        up_o  = upcase(order_reg);
        up_t  = upcase(trans_reg);
        is_cp = (up_t == CH_N) || (up_t == CH_R);
        is_tr = (up_t == CH_T) || (up_t == CH_C);
        is_cm = (up_o == CH_C);
        rr    = is_tr ? cols_reg : rows_reg;
        rc    = is_tr ? rows_reg : cols_reg;
        total = 14'(rows_reg) * 14'(cols_reg);
        top_idx = is_cm ? 14'(rr - 7'd1) + 14'(rc - 7'd1) * 14'(dst_ld_reg)
                        : 14'(rr - 7'd1) * 14'(dst_ld_reg) + 14'(rc - 7'd1);
        priority if (up_o != CH_C && up_o != CH_R)
            cfg_status = STAT_ORDER;
        else if (!is_cp && !is_tr)
            cfg_status = STAT_TRANS;
        else if (rows_reg == 7'd0)
            cfg_status = STAT_ROWS;
        else if (cols_reg == 7'd0)
            cfg_status = STAT_COLS;
        else if ((is_cm && src_ld_reg < rows_reg) || (!is_cm && src_ld_reg < cols_reg))
            cfg_status = STAT_SRC_LD;
        else
            cfg_status = STAT_OK;
        // destination stride wins over size and source stride errors
        if ((up_o == CH_C || up_o == CH_R) && (is_cp || is_tr)
            && dst_ld_reg < (is_cm ? rr : rc))
            cfg_status = STAT_DST_LD;
        if (cfg_status == STAT_OK)
        begin
            if (32'(rows_reg) > MAX_DIM || 32'(cols_reg) > MAX_DIM)
                cfg_status = STAT_OVERFLOW;
            else if (top_idx > INDEX_LIMIT)
                cfg_status = STAT_OVERFLOW;
        end
    end

    // operand decode
    logic [10:0] ea, eb;
    logic        x_nan, x_inf, x_zero, a_nan, a_inf, a_zero;
    logic        prod_sign;

    always_comb
    begin
        ea = in_data.value[62:52];
        eb = scale_reg[62:52];
        x_nan  = (ea == 11'h7FF) && (in_data.value[51:0] != 52'd0);
        x_inf  = (ea == 11'h7FF) && (in_data.value[51:0] == 52'd0);
        x_zero = (ea == 11'd0) && (in_data.value[51:0] == 52'd0);
        a_nan  = (eb == 11'h7FF) && (scale_reg[51:0] != 52'd0);
        a_inf  = (eb == 11'h7FF) && (scale_reg[51:0] == 52'd0);
        a_zero = (eb == 11'd0) && (scale_reg[51:0] == 52'd0);
        prod_sign = in_data.value[63] ^ scale_reg[63];
    end

    // partial product operands
    logic [26:0] op_a, op_b;
    logic [53:0] pp_mul;
    logic [6:0]  acc_sh;

    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0:    begin op_a = ma_reg[26:0];         op_b = mb_reg[26:0];         end
            2'd1:    begin op_a = ma_reg[26:0];         op_b = {1'b0, mb_reg[52:27]}; end
            2'd2:    begin op_a = {1'b0, ma_reg[52:27]}; op_b = mb_reg[26:0];         end
            default: begin op_a = {1'b0, ma_reg[52:27]}; op_b = {1'b0, mb_reg[52:27]}; end
        endcase
        pp_mul = 54'(op_a) * 54'(op_b);
        unique case (step_reg)
            3'd1:    acc_sh = 7'd0;
            3'd2:    acc_sh = 7'd27;
            3'd3:    acc_sh = 7'd27;
            default: acc_sh = 7'd54;
        endcase
    end

    // rounding
    logic [53:0]        mant_r;
    logic               rnd_up;
    logic signed [12:0] er_r;
    logic [63:0]        rnd_val;

    always_comb
    begin
        rnd_up = acc_reg[51] && (acc_reg[52] || (|acc_reg[50:0]) || sticky_reg);
        mant_r = {1'b0, acc_reg[104:52]} + 54'(rnd_up);
        er_r   = er_reg;
        if (mant_r[53])
        begin
            mant_r = mant_r >> 1;
            er_r   = er_reg + 13'sd1;
        end
        if (er_r >= 13'sd2047)
            rnd_val = {sign_reg, 11'h7FF, 52'd0};
        else if (mant_r[52])
            rnd_val = {sign_reg, er_r[10:0], mant_r[51:0]};
        else
            rnd_val = {sign_reg, 11'd0, mant_r[51:0]};
    end

    logic        out_free, in_fire, is_last;
    logic [6:0]  lr, lc;
    logic [13:0] k_now, dest_now;

    always_comb
    begin
        state_next   = state_reg;
        order_next   = order_reg;
        trans_next   = trans_reg;
        rows_next    = rows_reg;
        cols_next    = cols_reg;
        src_ld_next  = src_ld_reg;
        dst_ld_next  = dst_ld_reg;
        scale_next   = scale_reg;
        loaded_next  = loaded_reg;
        fetched_next = fetched_reg;
        li_next      = li_reg;
        lj_next      = lj_reg;
        fr_next      = fr_reg;
        fc_next      = fc_reg;
        k_next       = k_reg;
        sign_next    = sign_reg;
        ma_next      = ma_reg;
        mb_next      = mb_reg;
        er_next      = er_reg;
        step_next    = step_reg;
        pp_next      = pp_reg;
        acc_next     = acc_reg;
        sticky_next  = sticky_reg;
        fdest_next   = fdest_reg;
        flast_next   = flast_reg;
        out_next     = out_reg;
        wr_en        = 1'b0;
        wr_addr      = k_reg;
        wr_data      = rnd_val;
        rd_en        = 1'b0;
        rd_addr      = fetched_reg[ADDR_W-1:0];

        out_free = !out_valid_reg || !out_stall;
        out_valid_next = out_valid_reg && out_stall;
        in_stall = (state_reg != ST_IDLE) || !out_free;
        in_fire  = in_valid && !in_stall;

        lr = is_tr ? lj_reg : li_reg;
        lc = is_tr ? li_reg : lj_reg;
        k_now = is_cm ? 14'(lr) + 14'(lc) * 14'(rr) : 14'(lr) * 14'(rc) + 14'(lc);
        dest_now = is_cm ? 14'(fr_reg) + 14'(fc_reg) * 14'(dst_ld_reg)
                         : 14'(fr_reg) * 14'(dst_ld_reg) + 14'(fc_reg);
        is_last = (14'(fetched_reg) + 14'd1 == total);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    out_next = '{value_out: 64'd0, dest_index: 12'd0, last: 1'b0,
                                 status: cfg_status};
                    if (cfg_status != STAT_OK)
                        out_valid_next = 1'b1;
                    else if (!in_data.mode)
                    begin
                        if (14'(loaded_reg) >= total)
                        begin
                            out_next.status = STAT_NOT_READY;
                            out_valid_next  = 1'b1;
                        end
                        else
                        begin
                            k_next      = k_now[ADDR_W-1:0];
                            loaded_next = loaded_reg + 13'd1;
                            if (is_cm)
                            begin
                                if (li_reg + 7'd1 == rows_reg)
                                begin
                                    li_next = 7'd0;
                                    lj_next = lj_reg + 7'd1;
                                end
                                else
                                    li_next = li_reg + 7'd1;
                            end
                            else
                            begin
                                if (lj_reg + 7'd1 == cols_reg)
                                begin
                                    lj_next = 7'd0;
                                    li_next = li_reg + 7'd1;
                                end
                                else
                                    lj_next = lj_reg + 7'd1;
                            end
                            sign_next = prod_sign;
                            ma_next = {ea != 11'd0, in_data.value[51:0]};
                            mb_next = {eb != 11'd0, scale_reg[51:0]};
                            er_next = 13'((ea == 11'd0) ? 11'd1 : ea)
                                    + 13'((eb == 11'd0) ? 11'd1 : eb) - 13'sd1023;
                            acc_next    = '0;
                            sticky_next = 1'b0;
                            step_next   = 3'd0;
                            wr_addr     = k_now[ADDR_W-1:0];
                            // special operands are written right away
                            priority if (x_nan)
                            begin
                                wr_en   = 1'b1;
                                wr_data = in_data.value | 64'h0008_0000_0000_0000;
                            end
                            else if (a_nan)
                            begin
                                wr_en   = 1'b1;
                                wr_data = scale_reg | 64'h0008_0000_0000_0000;
                            end
                            else if ((x_inf && a_zero) || (x_zero && a_inf))
                            begin
                                wr_en   = 1'b1;
                                wr_data = 64'hFFF8_0000_0000_0000;
                            end
                            else if (x_inf || a_inf)
                            begin
                                wr_en   = 1'b1;
                                wr_data = {prod_sign, 11'h7FF, 52'd0};
                            end
                            else if (x_zero || a_zero)
                            begin
                                wr_en   = 1'b1;
                                wr_data = {prod_sign, 63'd0};
                            end
                            else
                                state_next = ST_MUL;
                            if (wr_en)
                                out_valid_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (14'(loaded_reg) < total || 14'(fetched_reg) >= total)
                        begin
                            out_next.status = STAT_NOT_READY;
                            out_valid_next  = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            fdest_next = dest_now[11:0];
                            flast_next = is_last;
                            state_next = ST_FETCH;
                            if (is_last)
                            begin
                                loaded_next  = 13'd0;
                                fetched_next = 13'd0;
                                li_next = 7'd0;
                                lj_next = 7'd0;
                                fr_next = 7'd0;
                                fc_next = 7'd0;
                            end
                            else
                            begin
                                fetched_next = fetched_reg + 13'd1;
                                if (is_cm)
                                begin
                                    if (fr_reg + 7'd1 == rr)
                                    begin
                                        fr_next = 7'd0;
                                        fc_next = fc_reg + 7'd1;
                                    end
                                    else
                                        fr_next = fr_reg + 7'd1;
                                end
                                else
                                begin
                                    if (fc_reg + 7'd1 == rc)
                                    begin
                                        fc_next = 7'd0;
                                        fr_next = fr_reg + 7'd1;
                                    end
                                    else
                                        fc_next = fc_reg + 7'd1;
                                end
                            end
                        end
                    end
                end
            end
            ST_MUL:
            begin
                // product registered, then accumulated in the following cycle
                if (step_reg != 3'd0)
                    acc_next = acc_reg + (106'(pp_reg) << acc_sh);
                if (step_reg != 3'd4)
                begin
                    pp_next   = pp_mul;
                    step_next = step_reg + 3'd1;
                end
                else
                    state_next = ST_NORM;
            end
            ST_NORM:
            begin
                // one bit a cycle until the leading one sits at bit 104 or the exponent is held at 1
                priority if (acc_reg[105])
                begin
                    sticky_next = sticky_reg | acc_reg[0];
                    acc_next    = acc_reg >> 1;
                    er_next     = er_reg + 13'sd1;
                end
                else if (acc_reg == '0)
                    state_next = ST_ROUND;
                else if (!acc_reg[104] && er_reg > 13'sd1)
                begin
                    acc_next = acc_reg << 1;
                    er_next  = er_reg - 13'sd1;
                end
                else if (er_reg < 13'sd1)
                begin
                    sticky_next = sticky_reg | acc_reg[0];
                    acc_next    = acc_reg >> 1;
                    er_next     = er_reg + 13'sd1;
                end
                else
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (out_free)
                begin
                    wr_en          = 1'b1;
                    out_next       = '{value_out: 64'd0, dest_index: 12'd0, last: 1'b0,
                                       status: STAT_OK};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                if (out_free)
                begin
                    out_next       = '{value_out: rd_data_reg, dest_index: fdest_reg,
                                       last: flast_reg, status: STAT_OK};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORDER:  order_next  = cfg_data[7:0];
                REG_TRANS:  trans_next  = cfg_data[7:0];
                REG_ROWS:   rows_next   = cfg_data[6:0];
                REG_COLS:   cols_next   = cfg_data[6:0];
                REG_SRC_LD: src_ld_next = cfg_data[6:0];
                REG_DST_LD: dst_ld_next = cfg_data[6:0];
                REG_SCALE:  scale_next  = cfg_data;
                default:    ;
            endcase
            if (cfg_index <= REG_SCALE)
            begin
                loaded_next  = 13'd0;
                fetched_next = 13'd0;
                li_next = 7'd0;
                lj_next = 7'd0;
                fr_next = 7'd0;
                fc_next = 7'd0;
            end
        end

        out_valid = out_valid_reg;
        out_data  = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            order_reg     <= CH_C;
            trans_reg     <= CH_N;
            rows_reg      <= 7'd1;
            cols_reg      <= 7'd1;
            src_ld_reg    <= 7'd1;
            dst_ld_reg    <= 7'd1;
            scale_reg     <= 64'h3FF0_0000_0000_0000;
            loaded_reg    <= 13'd0;
            fetched_reg   <= 13'd0;
            li_reg        <= 7'd0;
            lj_reg        <= 7'd0;
            fr_reg        <= 7'd0;
            fc_reg        <= 7'd0;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            order_reg     <= order_next;
            trans_reg     <= trans_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            src_ld_reg    <= src_ld_next;
            dst_ld_reg    <= dst_ld_next;
            scale_reg     <= scale_next;
            loaded_reg    <= loaded_next;
            fetched_reg   <= fetched_next;
            li_reg        <= li_next;
            lj_reg        <= lj_next;
            fr_reg        <= fr_next;
            fc_reg        <= fc_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        sign_reg   <= sign_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        er_reg     <= er_next;
        pp_reg     <= pp_next;
        acc_reg    <= acc_next;
        sticky_reg <= sticky_next;
        fdest_reg  <= fdest_next;
        flast_reg  <= flast_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire
